// ----- hdl/rpb_pkg.sv -----
// types, constants and helper functions shared by the rom prefetch buffer
package rpb_pkg;

   localparam logic [3:0] THUMB_CAPACITY = 4'd8;
   localparam logic [3:0] ARM_CAPACITY   = 4'd4;
   localparam logic [3:0] RESET_CAPACITY = 4'd8;
   localparam logic [3:0] HELD_MAX       = 4'd15;

   localparam logic [6:0] REGION_WS0 = 7'h04;
   localparam logic [6:0] REGION_WS1 = 7'h05;
   localparam logic [6:0] REGION_WS2 = 7'h06;
   localparam logic [4:0] OTHER_REGION_COST = 5'd1;

   localparam logic [4:0] WS0_RESET = 5'd3;
   localparam logic [4:0] WS1_RESET = 5'd5;
   localparam logic [4:0] WS2_RESET = 5'd9;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_STEP = 2'd1,
      FUNC_ROM  = 2'd2,
      FUNC_RSVD = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      REG_ENABLE = 2'd0,
      REG_WS0    = 2'd1,
      REG_WS1    = 2'd2,
      REG_WS2    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic       enable;
      logic [4:0] ws0;
      logic [4:0] ws1;
      logic [4:0] ws2;
   } cfg_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] address;
      logic [5:0]  cycles;
      logic [31:0] pc;
      logic        thumb;
      logic        dma_owns_bus;
   } req_item_type;

   typedef struct packed {
      logic [5:0] cycles_charged;
      logic [3:0] buffered_count;
      logic       fetch_busy;
   } rsp_item_type;

   function automatic logic [4:0] region_cost(input logic [7:0] top, input cfg_type cfg);
      logic [4:0] cost;
      if (top[7:1] == REGION_WS0) begin
         cost = cfg.ws0;
      end else if (top[7:1] == REGION_WS1) begin
         cost = cfg.ws1;
      end else if (top[7:1] == REGION_WS2) begin
         cost = cfg.ws2;
      end else begin
         cost = OTHER_REGION_COST;
      end
      return cost;
   endfunction

   // 4 bytes per opcode in arm state, 2 in thumb
   function automatic logic [31:0] opcode_step(input logic arm);
      return {29'd0, arm, ~arm, 1'b0};
   endfunction

endpackage

// ----- hdl/rpb_csr.sv -----
// configuration registers behind the apb-style port
module rpb_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output rpb_pkg::cfg_type  cfg
);
   import rpb_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_ENABLE: cfg_in.enable = csr_pwdata[0];
            REG_WS0:    cfg_in.ws0    = csr_pwdata[4:0];
            REG_WS1:    cfg_in.ws1    = csr_pwdata[4:0];
            REG_WS2:    cfg_in.ws2    = csr_pwdata[4:0];
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ENABLE: csr_prdata = {31'd0, cfg_ff.enable};
         REG_WS0:    csr_prdata = {27'd0, cfg_ff.ws0};
         REG_WS1:    csr_prdata = {27'd0, cfg_ff.ws1};
         REG_WS2:    csr_prdata = {27'd0, cfg_ff.ws2};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 1'b0, ws0: WS0_RESET, ws1: WS1_RESET, ws2: WS2_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/rpb_engine.sv -----
// prefetch state and the single-pass cost and next-state logic for one beat
module rpb_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  rpb_pkg::cfg_type       cfg,
   input  rpb_pkg::req_item_type  item,
   output rpb_pkg::rsp_item_type  result
);
   import rpb_pkg::*;

   logic        act_ff, act_in;
   logic [5:0]  cd_ff, cd_in;
   logic [3:0]  held_ff, held_in;
   logic [3:0]  cap_ff, cap_in;
   logic        arm_ff, arm_in;
   logic [5:0]  fcost_ff, fcost_in;
   logic [31:0] newest_ff, newest_in;
   logic [31:0] head_ff, head_in;
   logic [31:0] prev_ff, prev_in;

   logic [5:0]  tick_c;
   logic        keep_held;
   logic        do_other;
   logic        start;
   logic [4:0]  region;
   logic [5:0]  charged;

   always_comb begin
      act_in    = act_ff;
      cd_in     = cd_ff;
      held_in   = held_ff;
      cap_in    = cap_ff;
      arm_in    = arm_ff;
      fcost_in  = fcost_ff;
      newest_in = newest_ff;
      head_in   = head_ff;
      prev_in   = prev_ff;
      tick_c    = item.cycles;
      keep_held = 1'b0;
      do_other  = 1'b0;
      start     = 1'b0;
      region    = 5'd0;

      if (cfg.enable) begin
         unique case (item.func)
            FUNC_STEP: do_other = 1'b1;
            FUNC_ROM: begin
               prev_in = item.address;
               if (act_ff && item.address == newest_ff) begin
                  // hit on the fetch in flight
                  tick_c    = cd_ff;
                  keep_held = 1'b1;
               end else begin
                  act_in = 1'b0;
                  if (held_ff != 4'd0 && item.address == item.pc) begin
                     if (item.address == head_ff) begin
                        held_in  = held_ff - 4'd1;
                        head_in  = head_ff + opcode_step(arm_ff);
                        do_other = 1'b1;
                        tick_c   = 6'd1;
                     end else begin
                        held_in = 4'd0;
                     end
                  end
               end
            end
            default: tick_c = item.cycles;
         endcase
      end

      if (do_other) begin
         start = !act_in && (held_in < cap_in) && (item.pc == prev_in);
         if (start) begin
            if (held_in == 4'd0) begin
               region = region_cost(item.pc[31:24], cfg);
               if (item.thumb) begin
                  arm_in   = 1'b0;
                  cap_in   = THUMB_CAPACITY;
                  fcost_in = {1'b0, region};
               end else begin
                  arm_in   = 1'b1;
                  cap_in   = ARM_CAPACITY;
                  fcost_in = {region, 1'b0};
               end
               newest_in = item.pc + opcode_step(arm_in);
               head_in   = newest_in;
            end else begin
               newest_in = newest_in + opcode_step(arm_in);
            end
            cd_in  = fcost_in;
            act_in = 1'b1;
         end
      end

      // bus time elapses and counts down the fetch in flight
      charged = tick_c;
      if (act_in && !item.dma_owns_bus) begin
         if (tick_c >= cd_in) begin
            cd_in  = 6'd0;
            act_in = 1'b0;
            if (!keep_held && held_in != HELD_MAX) begin
               held_in = held_in + 4'd1;
            end
         end else begin
            cd_in = cd_in - tick_c;
         end
      end
   end

   assign result = '{cycles_charged: charged, buffered_count: held_in, fetch_busy: act_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= 1'b0;
         cd_ff     <= 6'd0;
         held_ff   <= 4'd0;
         cap_ff    <= RESET_CAPACITY;
         arm_ff    <= 1'b1;
         fcost_ff  <= 6'd0;
         newest_ff <= 32'd0;
         head_ff   <= 32'd0;
         prev_ff   <= 32'd0;
      end else if (fire) begin
         act_ff    <= act_in;
         cd_ff     <= cd_in;
         held_ff   <= held_in;
         cap_ff    <= cap_in;
         arm_ff    <= arm_in;
         fcost_ff  <= fcost_in;
         newest_ff <= newest_in;
         head_ff   <= head_in;
         prev_ff   <= prev_in;
      end
   end

endmodule

// ----- hdl/rom_prefetch_buffer.sv -----
// top level of the rom prefetch buffer cost model
//
// req channel: one beat per bus event; tuser carries the event kind (tick,
// idle or non-rom step, rom access), tdata the address, cycles, pc, thumb
// state and dma ownership. rsp channel: exactly one beat per req beat, in
// order, with the cycles charged, opcodes buffered and fetch-in-flight flag.
// csr port: apb-style, four registers at byte addresses 0, 4, 8 and 12
// (prefetch enable, then the sequential costs of the three wait-state
// regions); write only while no beat is outstanding.
// path: a req beat taken is held in the input register, is costed from
// there and its rsp beat is then registered in the output register.
// throughput: one beat per cycle while rsp_tready is high; the prefetch state
// is read and written in the same cycle, between the input and output registers.
// reset: synchronous, clears the valid flags of both registers and returns
// the prefetch state and registers to their reset values; no clearing pass is needed.
// stall: while rsp_tready is low the output register holds and the input
// register still takes one more beat before req_tready drops.
module rom_prefetch_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // address, cycles, pc, thumb, dma_owns_bus
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cycles_charged, buffered_count, fetch_busy, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rpb_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type in_item_ff;
   logic         in_valid_ff;
   rsp_item_type result;
   rsp_item_type out_item_ff;
   logic         out_valid_ff;
   logic         advance;

   assign req_item = '{
      func:         func_type'(req_tuser),
      address:      req_tdata[31:0],
      cycles:       req_tdata[37:32],
      pc:           req_tdata[69:38],
      thumb:        req_tdata[70],
      dma_owns_bus: req_tdata[71]
   };

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_item_ff.fetch_busy, out_item_ff.buffered_count,
                        out_item_ff.cycles_charged};

   rpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rpb_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

`ifndef SYNTHESIS
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("costed beat did not reach the output register");

   a_blocked_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("waiting input beat was lost or changed");

   a_drain_empties_output: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_tready && !in_valid_ff) |=> !out_valid_ff)
      else $error("rsp beat repeated after being taken");
`endif

endmodule
